// File: src/bre_pkg.sv
// Shared types and constants for the battery runtime estimator.
package bre_pkg;

	localparam int TS_W      = 32;
	localparam int RAW_LVL_W = 8;
	localparam int LEVEL_W   = 7;
	localparam int SRC_W     = 2;
	localparam int REMAIN_W  = 31;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int GAP_W     = 16;
	localparam int MIN_DROP_W = 7;
	localparam int MIN_SEC_W = 16;
	localparam int RATED_W   = 8;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;

	localparam logic [SRC_W-1:0] SRC_NONE  = 2'd0;
	localparam logic [SRC_W-1:0] SRC_USAGE = 2'd1;
	localparam logic [SRC_W-1:0] SRC_RATED = 2'd2;

	localparam logic [1:0] REG_MAX_GAP   = 2'd0;
	localparam logic [1:0] REG_MIN_DROP  = 2'd1;
	localparam logic [1:0] REG_MIN_CONN  = 2'd2;
	localparam logic [1:0] REG_RATED_HRS = 2'd3;

	localparam logic [GAP_W-1:0]      MAX_GAP_RST   = 16'd720;
	localparam logic [MIN_DROP_W-1:0] MIN_DROP_RST  = 7'd10;
	localparam logic [MIN_SEC_W-1:0]  MIN_CONN_RST  = 16'd3600;
	localparam logic [RATED_W-1:0]    RATED_HRS_RST = 8'd30;

	typedef struct packed {
		logic [GAP_W-1:0]      max_gap_seconds;
		logic [MIN_DROP_W-1:0] min_drop_percent;
		logic [MIN_SEC_W-1:0]  min_connected_seconds;
		logic [RATED_W-1:0]    rated_hours;
	} cfg_t;

endpackage

// File: src/bre_ifs.sv
// Sample and estimate channel interfaces.
interface bre_in_if;
	import bre_pkg::*;
	logic                        valid;
	logic                        ready;
	logic [TS_W-1:0]             timestamp_s;
	logic signed [RAW_LVL_W-1:0] level_percent;
	logic                        charging;
	modport source (output valid, timestamp_s, level_percent, charging, input ready);
	modport sink (input valid, timestamp_s, level_percent, charging, output ready);
endinterface

interface bre_out_if;
	import bre_pkg::*;
	logic                valid;
	logic                ready;
	logic [SRC_W-1:0]    estimate_source;
	logic [REMAIN_W-1:0] remaining_seconds;
	modport source (output valid, estimate_source, remaining_seconds, input ready);
	modport sink (input valid, estimate_source, remaining_seconds, output ready);
endinterface

// File: src/bre_regs.sv
// APB configuration registers.
module bre_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bre_pkg::PADDR_W-1:0]   paddr,
	input  logic [bre_pkg::PDATA_W-1:0]   pwdata,
	output logic [bre_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output bre_pkg::cfg_t                 cfg
);
	import bre_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;

	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_gap_seconds       <= MAX_GAP_RST;
			cfg_q.min_drop_percent      <= MIN_DROP_RST;
			cfg_q.min_connected_seconds <= MIN_CONN_RST;
			cfg_q.rated_hours           <= RATED_HRS_RST;
		end else if (wr) begin
			case (idx)
				REG_MAX_GAP:   cfg_q.max_gap_seconds       <= pwdata[GAP_W-1:0];
				REG_MIN_DROP:  cfg_q.min_drop_percent      <= pwdata[MIN_DROP_W-1:0];
				REG_MIN_CONN:  cfg_q.min_connected_seconds <= pwdata[MIN_SEC_W-1:0];
				REG_RATED_HRS: cfg_q.rated_hours           <= pwdata[RATED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_GAP:   prdata = PDATA_W'(cfg_q.max_gap_seconds);
			REG_MIN_DROP:  prdata = PDATA_W'(cfg_q.min_drop_percent);
			REG_MIN_CONN:  prdata = PDATA_W'(cfg_q.min_connected_seconds);
			REG_RATED_HRS: prdata = PDATA_W'(cfg_q.rated_hours);
			default:       prdata = '0;
		endcase
	end

endmodule

// File: src/bre_front.sv
// Sample intake: pair rule, running totals and estimate classification.
module bre_front #(
	parameter int SECONDS_WIDTH = 24,
	parameter int DROP_WIDTH    = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bre_in_if.sink                       samples,
	input  bre_pkg::cfg_t                cfg,
	input  logic                         job_ready,
	output logic                         job_valid,
	output logic [bre_pkg::SRC_W-1:0]    job_src,
	output logic [bre_pkg::LEVEL_W-1:0]  job_level,
	output logic [SECONDS_WIDTH-1:0]     job_seconds,
	output logic [DROP_WIDTH-1:0]        job_drop
);
	import bre_pkg::*;

	logic                     have_prev_q;
	logic [TS_W-1:0]          prev_time_q;
	logic [LEVEL_W-1:0]       prev_lvl_q;
	logic                     prev_disc_q;
	logic                     prev_chg_q;
	logic [SECONDS_WIDTH-1:0] sec_q;
	logic [DROP_WIDTH-1:0]    drop_q;

	logic                     accept;
	logic                     disc;
	logic                     chg;
	logic [LEVEL_W-1:0]       lvl;
	logic [TS_W-1:0]          step;
	logic                     gap_ok;
	logic                     clear;
	logic                     add;
	logic [SECONDS_WIDTH:0]   sec_sum;
	logic [DROP_WIDTH:0]      drop_sum;
	logic [LEVEL_W-1:0]       fall;
	logic [SECONDS_WIDTH-1:0] sec_next;
	logic [DROP_WIDTH-1:0]    drop_next;
	logic                     usage_ok;

	assign accept        = samples.valid & job_ready;
	assign samples.ready = job_ready;
	assign job_valid     = samples.valid;

	assign disc = samples.level_percent[RAW_LVL_W-1];
	assign chg  = samples.charging & ~disc;
	assign lvl  = disc ? '0 :
		(samples.level_percent[LEVEL_W-1:0] > LEVEL_FULL) ? LEVEL_FULL :
		samples.level_percent[LEVEL_W-1:0];

	assign step   = samples.timestamp_s - prev_time_q;
	assign gap_ok = (samples.timestamp_s >= prev_time_q) &&
		(step <= TS_W'(cfg.max_gap_seconds));
	assign clear  = have_prev_q & (prev_chg_q | chg);
	assign add    = have_prev_q & ~prev_chg_q & ~chg & ~prev_disc_q & ~disc & gap_ok;

	assign sec_sum  = {1'b0, sec_q} + (SECONDS_WIDTH + 1)'(step[GAP_W-1:0]);
	assign fall     = (prev_lvl_q > lvl) ? prev_lvl_q - lvl : '0;
	assign drop_sum = {1'b0, drop_q} + (DROP_WIDTH + 1)'(fall);

	always_comb begin
		sec_next  = sec_q;
		drop_next = drop_q;
		if (clear) begin
			sec_next  = '0;
			drop_next = '0;
		end else if (add) begin
			sec_next  = sec_sum[SECONDS_WIDTH] ? '1 : sec_sum[SECONDS_WIDTH-1:0];
			drop_next = drop_sum[DROP_WIDTH] ? '1 : drop_sum[DROP_WIDTH-1:0];
		end
	end

	assign usage_ok = (drop_next != '0) &&
		(drop_next >= DROP_WIDTH'(cfg.min_drop_percent)) &&
		(sec_next >= SECONDS_WIDTH'(cfg.min_connected_seconds));

	always_comb begin
		if (disc || chg) begin
			job_src = SRC_NONE;
		end else if (usage_ok) begin
			job_src = SRC_USAGE;
		end else begin
			job_src = SRC_RATED;
		end
	end

	assign job_level   = lvl;
	assign job_seconds = sec_next;
	assign job_drop    = drop_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_time_q <= '0;
			prev_lvl_q  <= '0;
			prev_disc_q <= 1'b1;
			prev_chg_q  <= 1'b0;
			sec_q       <= '0;
			drop_q      <= '0;
		end else if (accept) begin
			have_prev_q <= 1'b1;
			prev_time_q <= samples.timestamp_s;
			prev_lvl_q  <= lvl;
			prev_disc_q <= disc;
			prev_chg_q  <= chg;
			sec_q       <= sec_next;
			drop_q      <= drop_next;
		end
	end

endmodule

// File: src/bre_fifo.sv
// Two-entry request queue between intake and arithmetic.
module bre_fifo #(
	parameter int WIDTH = 43
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/bre_back.sv
// Estimate arithmetic: multiply, serial restoring divide, scale and output register.
module bre_back #(
	parameter int SECONDS_WIDTH = 24,
	parameter int DROP_WIDTH    = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	output logic                         job_ready,
	input  logic [bre_pkg::SRC_W-1:0]    job_src,
	input  logic [bre_pkg::LEVEL_W-1:0]  job_level,
	input  logic [SECONDS_WIDTH-1:0]     job_seconds,
	input  logic [DROP_WIDTH-1:0]        job_drop,
	input  bre_pkg::cfg_t                cfg,
	bre_out_if.source                    estimates
);
	import bre_pkg::*;

	localparam int PW = LEVEL_W + SECONDS_WIDTH;
	localparam int QW = (PW > 32) ? PW : 32;
	localparam int CW = $clog2(PW + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]               state_q;
	logic [SRC_W-1:0]         src_q;
	logic [LEVEL_W-1:0]       lvl_q;
	logic [SECONDS_WIDTH-1:0] sec_q;
	logic [DROP_WIDTH-1:0]    div_q;
	logic [PW-1:0]            acc_q;
	logic [DROP_WIDTH-1:0]    rem_q;
	logic [CW-1:0]            cnt_q;
	logic [REMAIN_W-1:0]      res_q;

	logic                     out_valid_q;
	logic [SRC_W-1:0]         out_src_q;
	logic [REMAIN_W-1:0]      out_rem_q;

	logic [DROP_WIDTH:0]      rem_shift;
	logic                     ge;
	logic [DROP_WIDTH:0]      rem_sub;
	logic [QW-1:0]            qx;
	logic                     sat;
	logic [REMAIN_W-1:0]      rated_scaled;
	logic [LEVEL_W+RATED_W-1:0] rated_prod;
	logic                     load_out;

	assign job_ready = (state_q == ST_IDLE);

	assign rem_shift = {rem_q, acc_q[PW-1]};
	assign ge        = rem_shift >= {1'b0, div_q};
	assign rem_sub   = rem_shift - {1'b0, div_q};

	assign qx  = QW'(acc_q);
	assign sat = |qx[QW-1:REMAIN_W];

	assign rated_prod   = acc_q[LEVEL_W+RATED_W-1:0];
	assign rated_scaled = REMAIN_W'({rated_prod, 5'b0}) + REMAIN_W'({rated_prod, 2'b0});

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || estimates.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= (job_src == SRC_NONE) ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q   <= CW'(PW);
					state_q <= (src_q == SRC_USAGE) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					src_q <= job_src;
					lvl_q <= job_level;
					sec_q <= job_seconds;
					div_q <= job_drop;
				end
			end
			ST_MUL: begin
				rem_q <= '0;
				if (src_q == SRC_USAGE) begin
					acc_q <= PW'(lvl_q * sec_q);
				end else begin
					acc_q <= PW'(cfg.rated_hours * lvl_q);
				end
			end
			ST_DIV: begin
				rem_q <= ge ? rem_sub[DROP_WIDTH-1:0] : rem_shift[DROP_WIDTH-1:0];
				acc_q <= {acc_q[PW-2:0], ge};
			end
			ST_FIN: begin
				case (src_q)
					SRC_USAGE: res_q <= sat ? '1 : qx[REMAIN_W-1:0];
					SRC_RATED: res_q <= rated_scaled;
					default:   res_q <= '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (estimates.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_src_q <= src_q;
			out_rem_q <= res_q;
		end
	end

	assign estimates.valid             = out_valid_q;
	assign estimates.estimate_source   = out_src_q;
	assign estimates.remaining_seconds = out_rem_q;

endmodule

// File: src/battery_runtime_estimator_core.sv
// Battery runtime estimator top level.
//
//   channel    dir  handshake      payload
//   samples    in   valid/ready    timestamp_s, level_percent, charging
//   estimates  out  valid/ready    estimate_source, remaining_seconds
//   apb        in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// Intake takes a sample when the two-entry queue has room and pushes a request.
// The arithmetic unit serves one request at a time: usage runs multiply, divide
// (one step per quotient bit), finish and done; rated skips the divide; no estimate
// skips multiply and divide; any may also wait on the output register.
// Asynchronous reset clears all control state; there is no clearing pass.
// A stalled output holds the arithmetic unit; the queue then fills and stalls intake.
module battery_runtime_estimator_core #(
	parameter int SECONDS_WIDTH = 24,
	parameter int DROP_WIDTH    = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bre_in_if.sink                      samples,
	bre_out_if.source                   estimates,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bre_pkg::PADDR_W-1:0] paddr,
	input  logic [bre_pkg::PDATA_W-1:0] pwdata,
	output logic [bre_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import bre_pkg::*;

	localparam int JOB_W = SRC_W + LEVEL_W + SECONDS_WIDTH + DROP_WIDTH;

	cfg_t                     cfg;
	logic                     f_valid;
	logic                     f_ready;
	logic [SRC_W-1:0]         f_src;
	logic [LEVEL_W-1:0]       f_level;
	logic [SECONDS_WIDTH-1:0] f_seconds;
	logic [DROP_WIDTH-1:0]    f_drop;
	logic [JOB_W-1:0]         push_data;
	logic                     b_valid;
	logic                     b_ready;
	logic [JOB_W-1:0]         pop_data;
	logic [SRC_W-1:0]         b_src;
	logic [LEVEL_W-1:0]       b_level;
	logic [SECONDS_WIDTH-1:0] b_seconds;
	logic [DROP_WIDTH-1:0]    b_drop;

	bre_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bre_front #(
		.SECONDS_WIDTH (SECONDS_WIDTH),
		.DROP_WIDTH    (DROP_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.cfg         (cfg),
		.job_ready   (f_ready),
		.job_valid   (f_valid),
		.job_src     (f_src),
		.job_level   (f_level),
		.job_seconds (f_seconds),
		.job_drop    (f_drop)
	);

	assign push_data = {f_src, f_level, f_seconds, f_drop};

	bre_fifo #(
		.WIDTH (JOB_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (push_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (pop_data)
	);

	assign {b_src, b_level, b_seconds, b_drop} = pop_data;

	bre_back #(
		.SECONDS_WIDTH (SECONDS_WIDTH),
		.DROP_WIDTH    (DROP_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (b_valid),
		.job_ready   (b_ready),
		.job_src     (b_src),
		.job_level   (b_level),
		.job_seconds (b_seconds),
		.job_drop    (b_drop),
		.cfg         (cfg),
		.estimates   (estimates)
	);

endmodule

// File: tb/bre_estimate_checker.sv
// Estimate checker: tracks register writes, predicts every estimate and compares results.
module bre_estimate_checker #(
	parameter int SECONDS_WIDTH = 24,
	parameter int DROP_WIDTH    = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bre_in_if                           samples,
	bre_out_if                          estimates,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [bre_pkg::PADDR_W-1:0] paddr,
	input  logic [bre_pkg::PDATA_W-1:0] pwdata,
	output int                          fail_count,
	output int                          pending
);
	import bre_pkg::*;

	localparam longint unsigned SECONDS_CAP = (64'd1 << SECONDS_WIDTH) - 64'd1;
	localparam longint unsigned DROP_CAP    = (64'd1 << DROP_WIDTH) - 64'd1;
	localparam longint unsigned REMAIN_CAP  = (64'd1 << REMAIN_W) - 64'd1;

	typedef struct packed {
		logic [SRC_W-1:0]    source;
		logic [REMAIN_W-1:0] remain;
	} estimate_t;

	estimate_t               expected_q[$];
	cfg_t                    regs;
	logic                    have_last;
	logic [TS_W-1:0]         last_time;
	int                      last_level;
	logic                    last_chg;
	logic [SECONDS_WIDTH-1:0] conn_total;
	logic [DROP_WIDTH-1:0]   drop_total;

	function automatic estimate_t predict_estimate(input logic [TS_W-1:0] ts,
			input logic [RAW_LVL_W-1:0] raw, input logic chg_in);
		int              lvl;
		logic            chg;
		logic [TS_W-1:0] step;
		logic [63:0]     sum;
		logic [63:0]     quot;
		estimate_t       est;
		chg = chg_in;
		if (raw[RAW_LVL_W-1]) begin
			lvl = -1;
			chg = 1'b0;
		end else begin
			lvl = (raw > 8'd100) ? 100 : int'(raw);
		end
		step = ts - last_time;
		if (have_last) begin
			if (last_chg || chg) begin
				conn_total = '0;
				drop_total = '0;
			end else if (last_level >= 0 && lvl >= 0 && ts >= last_time &&
					step <= regs.max_gap_seconds) begin
				sum = 64'(conn_total) + 64'(step);
				conn_total = (sum > SECONDS_CAP) ? '1 : sum[SECONDS_WIDTH-1:0];
				if (last_level > lvl) begin
					sum = 64'(drop_total) + 64'(last_level - lvl);
					drop_total = (sum > DROP_CAP) ? '1 : sum[DROP_WIDTH-1:0];
				end
			end
		end
		have_last  = 1'b1;
		last_time  = ts;
		last_level = lvl;
		last_chg   = chg;
		est.source = SRC_NONE;
		est.remain = '0;
		if (lvl >= 0 && !chg) begin
			if (drop_total != 0 && drop_total >= regs.min_drop_percent &&
					conn_total >= regs.min_connected_seconds) begin
				quot = (64'(lvl) * 64'(conn_total)) / 64'(drop_total);
				est.source = SRC_USAGE;
				est.remain = (quot > REMAIN_CAP) ? '1 : quot[REMAIN_W-1:0];
			end else begin
				est.source = SRC_RATED;
				est.remain = REMAIN_W'(64'(regs.rated_hours) * 64'd36 * 64'(lvl));
			end
		end
		return est;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		estimate_t want;
		estimate_t next_est;
		if (!arst_n) begin
			regs.max_gap_seconds       = MAX_GAP_RST;
			regs.min_drop_percent      = MIN_DROP_RST;
			regs.min_connected_seconds = MIN_CONN_RST;
			regs.rated_hours           = RATED_HRS_RST;
			have_last  = 1'b0;
			last_time  = '0;
			last_level = -1;
			last_chg   = 1'b0;
			conn_total = '0;
			drop_total = '0;
			expected_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_MAX_GAP:   regs.max_gap_seconds       = pwdata[GAP_W-1:0];
					REG_MIN_DROP:  regs.min_drop_percent      = pwdata[MIN_DROP_W-1:0];
					REG_MIN_CONN:  regs.min_connected_seconds = pwdata[MIN_SEC_W-1:0];
					REG_RATED_HRS: regs.rated_hours           = pwdata[RATED_W-1:0];
					default: ;
				endcase
			end
			if (estimates.valid && estimates.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected estimate: estimate_source %0d remaining_seconds %0d",
						estimates.estimate_source, estimates.remaining_seconds);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (estimates.estimate_source !== want.source) begin
						$error("estimate_source: expected %0d, got %0d",
							want.source, estimates.estimate_source);
						fail_count++;
					end
					if (estimates.remaining_seconds !== want.remain) begin
						$error("remaining_seconds: expected %0d, got %0d",
							want.remain, estimates.remaining_seconds);
						fail_count++;
					end
				end
			end
			if (samples.valid && samples.ready) begin
				next_est = predict_estimate(samples.timestamp_s,
					samples.level_percent, samples.charging);
				expected_q = {expected_q, next_est};
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Testbench top: clock, reset, sample and register stimulus, and the run verdict.
module tb_top;
	import bre_pkg::*;

	localparam int GAP_MAX      = 13;
	localparam int LONG_HOLD    = 300;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 60;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 fail_count;
	int                 pending;
	int                 idle_cycles = 0;
	int                 send_calm = 0;
	int                 take_calm = 0;
	int unsigned        gap_now;
	logic [TS_W-1:0]    run_time;
	int                 run_level;
	int                 charge_left;

	bre_in_if  samples();
	bre_out_if estimates();

	battery_runtime_estimator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.estimates (estimates),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	bre_estimate_checker estimate_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.estimates  (estimates),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (estimates.valid && estimates.ready) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int draw_wait(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, GAP_MAX);
	endfunction

	function automatic int unsigned draw_step(input bit wide_steps);
		int unsigned r;
		r = $urandom_range(0, 19);
		if (wide_steps)
			return $urandom_range(gap_now / 2, gap_now);
		if (r == 0)
			return gap_now;
		if (r == 1)
			return gap_now + 1;
		return $urandom_range(0, gap_now);
	endfunction

	task automatic write_register(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [GAP_W-1:0] gap, input logic [MIN_DROP_W-1:0] drop,
			input logic [MIN_SEC_W-1:0] conn, input logic [RATED_W-1:0] hrs);
		write_register(REG_MAX_GAP, PDATA_W'(gap));
		write_register(REG_MIN_DROP, PDATA_W'(drop));
		write_register(REG_MIN_CONN, PDATA_W'(conn));
		write_register(REG_RATED_HRS, PDATA_W'(hrs));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		gap_now = 32'(gap);
	endtask

	task automatic send_sample(input logic [TS_W-1:0] ts, input logic [RAW_LVL_W-1:0] lvl,
			input logic chg);
		int wait_cycles;
		wait_cycles = draw_wait(send_calm);
		if (wait_cycles != 0) begin
			samples.valid <= 1'b0;
			repeat (wait_cycles) @(negedge clk);
		end
		samples.valid         <= 1'b1;
		samples.timestamp_s   <= ts;
		samples.level_percent <= lvl;
		samples.charging      <= chg;
		do @(posedge clk); while (!samples.ready);
		@(negedge clk);
	endtask

	task automatic next_sample(input bit wide_steps, input int jump_pct,
			output logic [TS_W-1:0] ts, output logic [RAW_LVL_W-1:0] lvl, output logic chg);
		int roll;
		int delta;
		roll = wide_steps ? $urandom_range(20, 99) : $urandom_range(0, 99);
		chg = 1'b0;
		if (charge_left > 0) begin
			charge_left--;
			run_time += draw_step(1'b0);
			delta = $urandom_range(0, 30);
			run_level = (run_level + delta > 100) ? 100 : run_level + delta;
			chg = 1'b1;
		end else if (roll < 3) begin
			run_time -= $urandom_range(1, 5000);
		end else if (roll < 6) begin
			run_time += gap_now + $urandom_range(1, 100000);
			delta = $urandom_range(0, 3);
			run_level = (run_level < delta) ? 0 : run_level - delta;
		end else if (roll < 10) begin
			run_time += draw_step(1'b0);
			ts  = run_time;
			lvl = {1'b1, 7'($urandom)};
			chg = 1'($urandom_range(0, 1));
			return;
		end else if (roll < 12) begin
			run_time += draw_step(1'b0);
			run_level = 100;
			ts  = run_time;
			lvl = RAW_LVL_W'($urandom_range(101, 127));
			return;
		end else if (roll < 14) begin
			ts  = $urandom;
			lvl = RAW_LVL_W'($urandom);
			chg = 1'($urandom_range(0, 1));
			run_time = ts;
			if (!lvl[RAW_LVL_W-1])
				run_level = (lvl > 8'd100) ? 100 : int'(lvl);
			return;
		end else if (roll < 18) begin
			charge_left = $urandom_range(1, 6);
			run_time += draw_step(1'b0);
			chg = 1'b1;
		end else if (roll < 18 + jump_pct) begin
			run_time += draw_step(wide_steps);
			run_level = $urandom_range(0, 100);
		end else begin
			run_time += draw_step(wide_steps);
			delta = $urandom_range(0, 3);
			run_level = (run_level < delta) ? 0 : run_level - delta;
			if (run_level == 0 && !wide_steps)
				charge_left = $urandom_range(2, 6);
		end
		ts  = run_time;
		lvl = RAW_LVL_W'(run_level);
	endtask

	task automatic run_random(input int count, input bit wide_steps, input int jump_pct);
		logic [TS_W-1:0]      ts;
		logic [RAW_LVL_W-1:0] lvl;
		logic                 chg;
		repeat (count) begin
			next_sample(wide_steps, jump_pct, ts, lvl, chg);
			send_sample(ts, lvl, chg);
		end
	endtask

	task automatic finish_phase();
		samples.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	initial begin : receiver
		int wait_cycles;
		int taken;
		taken = 0;
		estimates.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			wait_cycles = (taken == 300 || taken == 1200) ? LONG_HOLD : draw_wait(take_calm);
			if (wait_cycles != 0) begin
				estimates.ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			estimates.ready <= 1'b1;
			do @(posedge clk); while (!estimates.valid);
			taken++;
		end
	end

	initial begin : stimulus
		int unsigned lvl;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		samples.valid         = 1'b0;
		samples.timestamp_s   = '0;
		samples.level_percent = '0;
		samples.charging      = 1'b0;
		gap_now     = 32'(MAX_GAP_RST);
		run_level   = 100;
		charge_left = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first sample, step at the gap limit, step just past it
		send_sample(32'd0, 8'd100, 1'b0);
		send_sample(32'd720, 8'd98, 1'b0);
		send_sample(32'd1441, 8'd97, 1'b0);
		// disconnected markers, one of them flagged charging
		send_sample(32'd1441, 8'hFF, 1'b1);
		send_sample(32'd1500, 8'h80, 1'b0);
		// level above full, time going backward, charging pair
		send_sample(32'd1600, 8'd127, 1'b0);
		send_sample(32'd1000, 8'd90, 1'b0);
		send_sample(32'd1720, 8'd88, 1'b1);
		send_sample(32'd1800, 8'd100, 1'b0);
		// discharge until both minimums are met exactly, then beyond
		lvl = 100;
		for (int i = 1; i <= 6; i++) begin
			lvl -= 2;
			send_sample(32'd1800 + 32'(i) * 32'd720, 8'(lvl), 1'b0);
		end
		send_sample(32'hFFFF_FFFF, 8'd0, 1'b0);
		send_sample(32'hFFFF_FFFF, 8'd0, 1'b0);
		send_sample(32'h0000_0010, 8'd50, 1'b0);
		run_time  = 32'h0000_0010;
		run_level = 50;
		run_random(150, 1'b0, 5);
		finish_phase();

		// widest gap and minimums: long discharge runs saturate both totals
		set_config(16'hFFFF, 7'd127, 16'hFFFF, 8'd255);
		run_random(420, 1'b1, 35);
		finish_phase();

		set_config(16'd1, 7'd1, 16'd1, 8'd1);
		run_random(200, 1'b0, 10);
		finish_phase();

		// zero minimums and zero rated life
		set_config(16'd0, 7'd0, 16'd0, 8'd0);
		run_random(150, 1'b0, 10);
		finish_phase();

		repeat (4) begin
			set_config(16'($urandom_range(60, 3000)), 7'($urandom_range(1, 30)),
				16'($urandom_range(1, 6000)), 8'($urandom_range(1, 255)));
			run_random(180, 1'b0, 5);
			finish_phase();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
